[rtl/gfc_pkg.sv]
// gfc_pkg: shared constants, op codes and state encoding for the first-fit
// graph coloring core. No dependencies; used by the core and gfc_first_fit.
package gfc_pkg;

	localparam int VERTICES   = 1024;
	localparam int NUM_COLORS = 64;

	localparam int V_W     = 10;   // vertex and neighbor field width
	localparam int COLOR_W = 7;    // color and colors_used field width
	localparam int POS_W   = 10;   // class_position field width
	localparam int CNT_W   = 11;   // class counter width
	localparam int OP_W    = 2;

	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int POS_MAX = (1 << POS_W) - 1;

	localparam int ADDR_W = $clog2(VERTICES);
	localparam int CLS_W  = $clog2(NUM_COLORS);

	// the clearing sweep covers both memories
	localparam int CLEAR_LEN = (VERTICES > NUM_COLORS) ? VERTICES : NUM_COLORS;
	localparam int CLR_W     = $clog2(CLEAR_LEN);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_COLOR = 2'd1,
		OP_MARK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND,
		ST_COUNT,
		ST_MARK
	} state_t;

endpackage

[rtl/greedy_first_fit_graph_coloring_core.sv]
// First-fit greedy graph coloring core. Neighbor color masks live in a
// VERTICES x NUM_COLORS memory and class counters in a NUM_COLORS x 11 memory,
// both with registered read data. After reset, and after every clear
// item, the core sweeps both memories to zero, one entry per cycle, over
// max(VERTICES, NUM_COLORS) entries (1024 here) with in_stall high. A color
// item runs a mask read, then a first-fit pick and counter read, then a
// counter update and result load, held at that last step only while a waiting
// result is stalled; a neighbor item runs a mask read, then a mask write back;
// ignored items are dropped. Items are handled one at a time, so each read
// sees every earlier write. A new item is taken while the last result still
// waits in the output register. Depends on gfc_pkg, gfc_ram, gfc_first_fit.
module greedy_first_fit_graph_coloring_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [gfc_pkg::OP_W-1:0]        op,
	input  logic [gfc_pkg::V_W-1:0]         vertex,
	input  logic [gfc_pkg::V_W-1:0]         neighbor,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [gfc_pkg::V_W-1:0]         colored_vertex,
	output logic [gfc_pkg::COLOR_W-1:0]     color,
	output logic [gfc_pkg::POS_W-1:0]       class_position,
	output logic [gfc_pkg::COLOR_W-1:0]     colors_used,
	output logic                            overflow
);

	gfc_pkg::state_t state_q, state_d;
	gfc_pkg::op_t    op_in;

	logic [gfc_pkg::CLR_W-1:0]   clr_idx_q;
	logic [gfc_pkg::COLOR_W-1:0] highest_q;
	logic [gfc_pkg::COLOR_W-1:0] cur_color_q;
	logic                        cur_ovf_q;
	logic                        out_valid_q;

	logic [gfc_pkg::V_W-1:0]     vertex_q;
	logic [gfc_pkg::ADDR_W-1:0]  addr_q;
	logic                        in_range_q;
	logic [gfc_pkg::COLOR_W-1:0] found_q;

	logic [gfc_pkg::V_W-1:0]     colored_vertex_q;
	logic [gfc_pkg::COLOR_W-1:0] color_q;
	logic [gfc_pkg::POS_W-1:0]   class_position_q;
	logic [gfc_pkg::COLOR_W-1:0] colors_used_q;
	logic                        overflow_q;

	logic accept, out_free, mark_ok, in_range_d;

	// mask memory ports
	logic                           bits_we, bits_re;
	logic [gfc_pkg::ADDR_W-1:0]     bits_waddr, bits_raddr;
	logic [gfc_pkg::NUM_COLORS-1:0] bits_wdata, bits_rdata, bits_eff, mark_mask;

	// class counter memory ports
	logic                        cnt_we, cnt_re;
	logic [gfc_pkg::CLS_W-1:0]   cnt_waddr, cnt_raddr;
	logic [gfc_pkg::CNT_W-1:0]   cnt_wdata, cnt_rdata, cnt_eff;

	logic [gfc_pkg::COLOR_W-1:0] enc_color;
	logic [gfc_pkg::COLOR_W-1:0] highest_new;
	logic [gfc_pkg::POS_W-1:0]   pos;

	assign op_in    = gfc_pkg::op_t'(op);
	assign in_stall = (state_q != gfc_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign mark_ok  = (cur_color_q != '0) && !cur_ovf_q;

	always_comb begin
		if (op_in == gfc_pkg::OP_MARK) begin
			in_range_d = int'(neighbor) < gfc_pkg::VERTICES;
		end else begin
			in_range_d = int'(vertex) < gfc_pkg::VERTICES;
		end
	end

	gfc_ram #(
		.DEPTH(gfc_pkg::VERTICES),
		.WIDTH(gfc_pkg::NUM_COLORS)
	) u_bits_ram (
		.clk  (clk),
		.we   (bits_we),
		.waddr(bits_waddr),
		.wdata(bits_wdata),
		.re   (bits_re),
		.raddr(bits_raddr),
		.rdata(bits_rdata)
	);

	gfc_ram #(
		.DEPTH(gfc_pkg::NUM_COLORS),
		.WIDTH(gfc_pkg::CNT_W)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (cnt_re),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	// an out-of-range vertex has no colored neighbors
	assign bits_eff = in_range_q ? bits_rdata : '0;

	gfc_first_fit u_first_fit (
		.used_bits(bits_eff),
		.highest  (highest_q),
		.color    (enc_color)
	);

	assign mark_mask = gfc_pkg::NUM_COLORS'(1) << (cur_color_q - 1'b1);

	assign cnt_eff     = (found_q != '0) ? cnt_rdata : '0;
	assign pos         = (int'(cnt_eff) > gfc_pkg::POS_MAX) ?
	                     gfc_pkg::POS_W'(gfc_pkg::POS_MAX) : gfc_pkg::POS_W'(cnt_eff);
	assign highest_new = (found_q > highest_q) ? found_q : highest_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gfc_pkg::ST_CLEAR: begin
				if (clr_idx_q == gfc_pkg::CLR_W'(gfc_pkg::CLEAR_LEN - 1)) begin
					state_d = gfc_pkg::ST_IDLE;
				end
			end
			gfc_pkg::ST_IDLE: begin
				if (accept) begin
					case (op_in)
						gfc_pkg::OP_CLEAR: state_d = gfc_pkg::ST_CLEAR;
						gfc_pkg::OP_COLOR: state_d = gfc_pkg::ST_FIND;
						gfc_pkg::OP_MARK: begin
							if (mark_ok) begin
								state_d = gfc_pkg::ST_MARK;
							end
						end
						default: state_d = gfc_pkg::ST_IDLE;
					endcase
				end
			end
			gfc_pkg::ST_FIND:  state_d = gfc_pkg::ST_COUNT;
			gfc_pkg::ST_COUNT: begin
				if (out_free) begin
					state_d = gfc_pkg::ST_IDLE;
				end
			end
			gfc_pkg::ST_MARK:  state_d = gfc_pkg::ST_IDLE;
			default:           state_d = gfc_pkg::ST_CLEAR;
		endcase
	end

	// memory controls
	always_comb begin
		bits_we    = 1'b0;
		bits_re    = 1'b0;
		bits_waddr = addr_q;
		bits_raddr = gfc_pkg::ADDR_W'(vertex);
		bits_wdata = bits_rdata | mark_mask;
		cnt_we     = 1'b0;
		cnt_re     = 1'b0;
		cnt_waddr  = gfc_pkg::CLS_W'(found_q - 1'b1);
		cnt_raddr  = gfc_pkg::CLS_W'(enc_color - 1'b1);
		cnt_wdata  = cnt_rdata + 1'b1;
		case (state_q)
			gfc_pkg::ST_CLEAR: begin
				bits_we    = int'(clr_idx_q) < gfc_pkg::VERTICES;
				bits_waddr = gfc_pkg::ADDR_W'(clr_idx_q);
				bits_wdata = '0;
				cnt_we     = int'(clr_idx_q) < gfc_pkg::NUM_COLORS;
				cnt_waddr  = gfc_pkg::CLS_W'(clr_idx_q);
				cnt_wdata  = '0;
			end
			gfc_pkg::ST_IDLE: begin
				if (accept && op_in == gfc_pkg::OP_COLOR) begin
					bits_re = 1'b1;
				end else if (accept && op_in == gfc_pkg::OP_MARK && mark_ok) begin
					bits_re    = 1'b1;
					bits_raddr = gfc_pkg::ADDR_W'(neighbor);
				end
			end
			gfc_pkg::ST_FIND: begin
				cnt_re = 1'b1;
			end
			gfc_pkg::ST_COUNT: begin
				// counter saturates
				cnt_we = out_free && (found_q != '0) &&
				         (int'(cnt_rdata) < gfc_pkg::CNT_MAX);
			end
			gfc_pkg::ST_MARK: begin
				bits_we = in_range_q;
			end
			default: begin
				bits_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gfc_pkg::ST_CLEAR;
			clr_idx_q   <= '0;
			highest_q   <= '0;
			cur_color_q <= '0;
			cur_ovf_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gfc_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (accept && op_in == gfc_pkg::OP_CLEAR) begin
				clr_idx_q   <= '0;
				highest_q   <= '0;
				cur_color_q <= '0;
				cur_ovf_q   <= 1'b0;
			end
			if (state_q == gfc_pkg::ST_COUNT && out_free) begin
				highest_q   <= highest_new;
				cur_color_q <= found_q;
				cur_ovf_q   <= (found_q == '0);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vertex_q   <= vertex;
			addr_q     <= gfc_pkg::ADDR_W'(neighbor);
			in_range_q <= in_range_d;
		end
		if (state_q == gfc_pkg::ST_FIND) begin
			found_q <= enc_color;
		end
		if (state_q == gfc_pkg::ST_COUNT && out_free) begin
			colored_vertex_q <= vertex_q;
			color_q          <= found_q;
			class_position_q <= pos;
			colors_used_q    <= highest_new;
			overflow_q       <= (found_q == '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign colored_vertex = colored_vertex_q;
	assign color          = color_q;
	assign class_position = class_position_q;
	assign colors_used    = colors_used_q;
	assign overflow       = overflow_q;

endmodule

[rtl/gfc_ram.sv]
// gfc_ram: generic single-port-write, single-port-read synchronous memory
// with registered read data. Depends on nothing.
module gfc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/gfc_first_fit.sv]
// gfc_first_fit: priority encoder that picks the lowest color not held by a
// neighbor, treating colors above the highest used as free. Uses gfc_pkg.
module gfc_first_fit (
	input  logic [gfc_pkg::NUM_COLORS-1:0] used_bits,
	input  logic [gfc_pkg::COLOR_W-1:0]    highest,
	output logic [gfc_pkg::COLOR_W-1:0]    color
);

	logic [gfc_pkg::NUM_COLORS-1:0] free;

	always_comb begin
		for (int i = 0; i < gfc_pkg::NUM_COLORS; i++) begin
			free[i] = !used_bits[i] || ((i + 1) > int'(highest));
		end
	end

	// lowest free color wins, 0 means none left
	always_comb begin
		color = '0;
		for (int i = gfc_pkg::NUM_COLORS - 1; i >= 0; i--) begin
			if (free[i]) begin
				color = gfc_pkg::COLOR_W'(i + 1);
			end
		end
	end

endmodule
